// ===== hw/rtl/clss_pkg.sv =====
`default_nettype none

package clss_pkg;

  // Sizing of the search chain and the stream counters
  localparam int MAX_PATTERN  = 32;
  localparam int OFFSET_BITS  = 40;
  localparam int LINE_BITS    = 32;

  // Fixed widths of the channel and register fields
  localparam int BYTE_W       = 8;
  localparam int LINE_OUT_W   = 32;
  localparam int OFFSET_OUT_W = 40;
  localparam int PAT_LEN_W    = 6;
  localparam int CNT_W        = 32;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int NUM_PAT_REGS = 4;
  localparam int PAT_REG_BYTES = CFG_DATA_W / BYTE_W;
  localparam int LINE_CMP_W   = (LINE_BITS > CNT_W) ? LINE_BITS : CNT_W;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PAT0        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT1        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT2        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT3        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LINE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LIMIT = 3'd6;

  // Register reset values
  localparam logic [PAT_LEN_W-1:0] PAT_LEN_RST     = 6'd1;
  localparam logic [CNT_W-1:0]     START_LINE_RST  = 32'd1;
  localparam logic [CNT_W-1:0]     MATCH_LIMIT_RST = 32'd20;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_UC_A    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UC_Z    = 8'h5A;
  localparam logic [BYTE_W-1:0] FOLD_DELTA = 8'h20;

  // Counter limits
  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  // Settings seen by the datapath
  typedef struct packed {
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_fold;
    logic [PAT_LEN_W-1:0]               pat_len;
    logic [CNT_W-1:0]                   start_line;
    logic [CNT_W-1:0]                   match_limit;
  } clss_cfg_t;

  // Per-byte control sent to every cell of the chain
  typedef struct packed {
    logic shift;
    logic clear;
  } clss_ctl_t;

  // Map ASCII upper case to lower case
  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= CH_UC_A && c <= CH_UC_Z) begin
      r = c + FOLD_DELTA;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/clss_if.sv =====
`default_nettype none

interface clss_in_if;
  import clss_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface clss_out_if;
  import clss_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [LINE_OUT_W-1:0]   line_number;
  logic [OFFSET_OUT_W-1:0] line_offset;
  logic                    is_match;
  logic                    stream_done;

  modport source (output valid, output line_number, output line_offset,
                  output is_match, output stream_done, input ready);
  modport sink   (input valid, input line_number, input line_offset,
                  input is_match, input stream_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/caseless_line_substring_search.sv =====
`default_nettype none

// Channel   Dir  Payload                                          Transfer
// text_in   in   text_byte[7:0], end_of_text                      valid && ready
// res_out   out  line_number[31:0], line_offset[39:0],            valid && ready
//                is_match, stream_done
// cfg       in   cfg_idx_i[2:0], cfg_wdata_i[63:0]                cfg_we_i
//
// One byte per cycle unless stalled; a result is registered in the cycle after its byte.
// The chain of match cells compares every pattern position against each byte at once.
// Reset gives pattern length 1, start line 1, match limit 20 and an empty stream.
// Input is held off only while a result waits in the output register and the sink stalls.

module caseless_line_substring_search
  import clss_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  clss_in_if.sink                    text_in,
  clss_out_if.source                 res_out,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  clss_cfg_t cfg;

  clss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic                    accept;
  logic [BYTE_W-1:0]       byte_fold;
  logic                    is_lf;
  logic                    is_cr;
  logic                    eot;
  clss_ctl_t               ctl;
  logic [MAX_PATTERN-1:0]  link_q;
  logic [MAX_PATTERN-1:0]  hit_next;
  logic [MAX_PATTERN-1:0]  len_sel;
  logic                    len_ok;
  logic                    win_hit;

  logic                    line_hit_q, line_hit_d;
  logic                    hit_ret_q, hit_ret_d;
  logic [LINE_BITS-1:0]    cur_line_q, cur_line_d;
  logic [OFFSET_BITS-1:0]  line_start_q, line_start_d;
  logic [OFFSET_BITS-1:0]  byte_pos_q, byte_pos_d;
  logic [CNT_W-1:0]        reported_q, reported_d;

  logic                    hit_eff;
  logic                    eligible;
  logic                    report;
  logic                    load;
  logic [OFFSET_BITS-1:0]  next_pos;

  logic                    out_valid_q, out_valid_d;
  logic [LINE_OUT_W-1:0]   out_line_q;
  logic [OFFSET_OUT_W-1:0] out_off_q;
  logic                    out_match_q;
  logic                    out_done_q;

  // Input side of the handshake
  assign text_in.ready = !out_valid_q || res_out.ready;
  assign accept        = text_in.valid && text_in.ready;
  assign byte_fold     = fold(text_in.text_byte);
  assign is_lf         = (text_in.text_byte == CH_LF);
  assign is_cr         = (text_in.text_byte == CH_CR);
  assign eot           = text_in.end_of_text;

  // Shift on every byte of a line; drop the chain at a line or stream end
  assign ctl.shift = accept && !is_lf;
  assign ctl.clear = accept && (is_lf || eot);

  // Chain of cells, one per pattern position
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic link_in;
    if (j == 0) begin : g_head
      assign link_in = 1'b1;
    end else begin : g_body
      assign link_in = link_q[j-1];
    end

    clss_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .byte_i (byte_fold),
      .pat_i  (cfg.pat_fold[j]),
      .link_i (link_in),
      .link_o (link_q[j]),
      .hit_o  (hit_next[j])
    );

    assign len_sel[j] = (32'(cfg.pat_len) == 32'(j + 1));
  end

  // Full pattern seen at the current byte
  assign len_ok  = (cfg.pat_len != '0) && (32'(cfg.pat_len) <= 32'(MAX_PATTERN));
  assign win_hit = len_ok && |(hit_next & len_sel);

  // Line status after this byte, counting a held return that proved not trailing
  always_comb begin
    hit_eff = line_hit_q;
    if (!is_lf) begin
      hit_eff = line_hit_q || hit_ret_q || (win_hit && !is_cr);
    end
  end

  assign eligible = (LINE_CMP_W'(cur_line_q) >= LINE_CMP_W'(cfg.start_line)) &&
                    (reported_q < cfg.match_limit);
  assign report   = (is_lf || eot) && hit_eff && eligible;
  assign next_pos = (byte_pos_q == OFF_MAX) ? byte_pos_q : byte_pos_q + 1'b1;
  assign load     = accept && (report || eot);

  // Stream state update
  always_comb begin
    line_hit_d   = line_hit_q;
    hit_ret_d    = hit_ret_q;
    cur_line_d   = cur_line_q;
    line_start_d = line_start_q;
    byte_pos_d   = byte_pos_q;
    reported_d   = reported_q;
    if (accept) begin
      if (eot) begin
        line_hit_d   = 1'b0;
        hit_ret_d    = 1'b0;
        cur_line_d   = LINE_BITS'(1);
        line_start_d = '0;
        byte_pos_d   = '0;
        reported_d   = '0;
      end else if (is_lf) begin
        line_hit_d   = 1'b0;
        hit_ret_d    = 1'b0;
        cur_line_d   = (cur_line_q == LINE_MAX) ? cur_line_q : cur_line_q + 1'b1;
        line_start_d = next_pos;
        byte_pos_d   = next_pos;
        reported_d   = reported_q + CNT_W'(report);
      end else begin
        line_hit_d   = hit_eff;
        hit_ret_d    = win_hit && is_cr;
        byte_pos_d   = next_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_hit_q   <= 1'b0;
      hit_ret_q    <= 1'b0;
      cur_line_q   <= LINE_BITS'(1);
      line_start_q <= '0;
      byte_pos_q   <= '0;
      reported_q   <= '0;
    end else begin
      line_hit_q   <= line_hit_d;
      hit_ret_q    <= hit_ret_d;
      cur_line_q   <= cur_line_d;
      line_start_q <= line_start_d;
      byte_pos_q   <= byte_pos_d;
      reported_q   <= reported_d;
    end
  end

  // Output register: load a result, release it on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (res_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_line_q  <= report ? LINE_OUT_W'(cur_line_q) : '0;
      out_off_q   <= report ? OFFSET_OUT_W'(line_start_q) : '0;
      out_match_q <= report;
      out_done_q  <= eot;
    end
  end

  assign res_out.valid       = out_valid_q;
  assign res_out.line_number = out_line_q;
  assign res_out.line_offset = out_off_q;
  assign res_out.is_match    = out_match_q;
  assign res_out.stream_done = out_done_q;

`ifndef SYNTHESIS
  // A done result without a match carries no line
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out.valid && !res_out.is_match |-> res_out.line_number == '0 &&
    res_out.line_offset == '0)
    else $error("done result without match carries a line");

  // The last byte of a stream always leaves a done result
  a_eot_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eot |=> res_out.valid && res_out.stream_done)
    else $error("end of stream gave no done result");

  // The last byte of a stream clears the stream counters
  a_eot_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && eot |=> cur_line_q == LINE_BITS'(1) && byte_pos_q == '0 &&
    reported_q == '0 && !line_hit_q && !hit_ret_q)
    else $error("stream state not cleared after end of stream");

  // Input is held off only behind a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !text_in.ready |-> res_out.valid && !res_out.ready)
    else $error("input stalled without a pending result");

  // A line never starts beyond the current position
  a_line_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_start_q <= byte_pos_q)
    else $error("line start beyond byte position");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/clss_cell.sv =====
`default_nettype none

module clss_cell
  import clss_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire clss_ctl_t         ctl_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire logic [BYTE_W-1:0] pat_i,
  input  wire logic              link_i,
  output logic                   link_o,
  output logic                   hit_o
);

  logic match_q;
  logic match_d;

  // Extend the prefix match of the left neighbor by the incoming byte
  assign match_d = link_i && (byte_i == pat_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.clear) begin
      match_q <= 1'b0;
    end else if (ctl_i.shift) begin
      match_q <= match_d;
    end
  end

  assign link_o = match_q;
  assign hit_o  = match_d;

endmodule

`default_nettype wire

// ===== hw/rtl/clss_cfg.sv =====
`default_nettype none

module clss_cfg
  import clss_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output clss_cfg_t                  cfg_o
);

  logic [NUM_PAT_REGS-1:0][CFG_DATA_W-1:0] pat_q;
  logic [PAT_LEN_W-1:0]                    pat_len_q;
  logic [CNT_W-1:0]                        start_line_q;
  logic [CNT_W-1:0]                        match_limit_q;

  // Take register writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q         <= '0;
      pat_len_q     <= PAT_LEN_RST;
      start_line_q  <= START_LINE_RST;
      match_limit_q <= MATCH_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAT0:        pat_q[0]      <= cfg_wdata_i;
        CFG_PAT1:        pat_q[1]      <= cfg_wdata_i;
        CFG_PAT2:        pat_q[2]      <= cfg_wdata_i;
        CFG_PAT3:        pat_q[3]      <= cfg_wdata_i;
        CFG_PAT_LEN:     pat_len_q     <= cfg_wdata_i[PAT_LEN_W-1:0];
        CFG_START_LINE:  start_line_q  <= cfg_wdata_i[CNT_W-1:0];
        CFG_MATCH_LIMIT: match_limit_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Fold pattern bytes; bytes past the registers read as zero
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat
    if (j < NUM_PAT_REGS * PAT_REG_BYTES) begin : g_held
      assign cfg_o.pat_fold[j] =
        fold(pat_q[j / PAT_REG_BYTES][(j % PAT_REG_BYTES) * BYTE_W +: BYTE_W]);
    end else begin : g_zero
      assign cfg_o.pat_fold[j] = '0;
    end
  end

  assign cfg_o.pat_len     = pat_len_q;
  assign cfg_o.start_line  = start_line_q;
  assign cfg_o.match_limit = match_limit_q;

endmodule

`default_nettype wire
